// ===== hdl/lc4_pkg.sv =====
package lc4_pkg;

   typedef logic [15:0] word_type;

   localparam word_type RESET_PC      = 16'h8200;
   localparam word_type FAULT_PC      = 16'h80FF;
   localparam word_type USER_CODE_END = 16'h2000;
   localparam word_type OS_BASE       = 16'h8000;
   localparam logic [2:0] NZP_N = 3'd4;
   localparam logic [2:0] NZP_Z = 3'd2;
   localparam logic [2:0] NZP_P = 3'd1;

   localparam logic [3:0] OP_BR    = 4'd0;
   localparam logic [3:0] OP_ARITH = 4'd1;
   localparam logic [3:0] OP_CMP   = 4'd2;
   localparam logic [3:0] OP_JSR   = 4'd4;
   localparam logic [3:0] OP_LOGIC = 4'd5;
   localparam logic [3:0] OP_LDR   = 4'd6;
   localparam logic [3:0] OP_STR   = 4'd7;
   localparam logic [3:0] OP_RTI   = 4'd8;
   localparam logic [3:0] OP_CONST = 4'd9;
   localparam logic [3:0] OP_SHIFT = 4'd10;
   localparam logic [3:0] OP_JMP   = 4'd12;
   localparam logic [3:0] OP_HICON = 4'd13;
   localparam logic [3:0] OP_TRAP  = 4'd15;

   localparam logic [2:0] ALU_ADD = 3'd0;
   localparam logic [2:0] ALU_MUL = 3'd1;
   localparam logic [2:0] ALU_SUB = 3'd2;
   localparam logic [2:0] ALU_DIV = 3'd3;

   localparam logic [2:0] LOG_AND = 3'd0;
   localparam logic [2:0] LOG_NOT = 3'd1;
   localparam logic [2:0] LOG_OR  = 3'd2;
   localparam logic [2:0] LOG_XOR = 3'd3;

   localparam logic [1:0] CMP_S  = 2'd0;
   localparam logic [1:0] CMP_U  = 2'd1;
   localparam logic [1:0] CMP_SI = 2'd2;

   localparam logic [1:0] SH_SLL = 2'd0;
   localparam logic [1:0] SH_SRA = 2'd1;
   localparam logic [1:0] SH_SRL = 2'd2;
   localparam logic [1:0] SH_MOD = 2'd3;

   typedef struct packed {
      logic capture;
      logic mem_rd_pc;
      logic latch_insn;
      logic div_start;
      logic mem_rd_addr;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_cmd;
      logic halted;
      logic fault;
      logic is_div;
      logic is_ldr;
      logic div_done;
   } dp_status_type;

endpackage

// ===== hdl/lc4_stream_if.sv =====
interface lc4_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [15:0] load_addr;
   logic [15:0] load_data;
   modport source (output valid, cmd, load_addr, load_data, input ready);
   modport sink   (input valid, cmd, load_addr, load_data, output ready);
endinterface

interface lc4_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] exec_pc;
   logic [15:0] insn_word;
   logic        reg_we;
   logic [2:0]  reg_num;
   logic [15:0] reg_value;
   logic        nzp_we;
   logic [2:0]  nzp;
   logic        mem_we;
   logic [15:0] mem_addr;
   logic [15:0] mem_value;
   logic        fault;
   modport source (output valid, exec_pc, insn_word, reg_we, reg_num, reg_value,
                   nzp_we, nzp, mem_we, mem_addr, mem_value, fault, input ready);
   modport sink   (input valid, exec_pc, insn_word, reg_we, reg_num, reg_value,
                   nzp_we, nzp, mem_we, mem_addr, mem_value, fault, output ready);
endinterface

// ===== hdl/sixteen_bit_instruction_executor.sv =====
// channel   dir  handshake     payload
// req_ch    in   valid/ready   cmd, load_addr, load_data
// rsp_ch    out  valid/ready   exec_pc .. fault (one trace per transaction)
// csr       in   csr_we        csr_wdata -> PC, loaded while csr_we is high
//
// Steps: memory load and halted execute go from idle to finish; others run
// fetch, decode, execute and finish, DIV/MOD waiting on the serial divider.
// One transaction in flight; the next is taken while a trace waits in the
// output register. Reset is synchronous: PC 0x8200, privileged, NZP zero,
// registers cleared; memory contents are not reset.
// A stalled rsp_ch holds the trace and the controller waits in its final state.
module sixteen_bit_instruction_executor (
   input  logic              clock,
   input  logic              reset,
   lc4_req_if.sink           req_ch,
   lc4_rsp_if.source         rsp_ch,
   input  logic              csr_we,
   input  lc4_pkg::word_type csr_wdata
);
   import lc4_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type st;

   // sequencing: fetch, decode, execute, optional divide, retire; loads and halted requests go straight to retire
   lc4_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .st        (st),
      .cmd       (cmd)
   );

   // architectural state, memory, divider and trace register
   lc4_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .in_cmd       (req_ch.cmd),
      .in_load_addr (req_ch.load_addr),
      .in_load_data (req_ch.load_data),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .st           (st),
      .o_exec_pc    (rsp_ch.exec_pc),
      .o_insn_word  (rsp_ch.insn_word),
      .o_reg_we     (rsp_ch.reg_we),
      .o_reg_num    (rsp_ch.reg_num),
      .o_reg_value  (rsp_ch.reg_value),
      .o_nzp_we     (rsp_ch.nzp_we),
      .o_nzp        (rsp_ch.nzp),
      .o_mem_we     (rsp_ch.mem_we),
      .o_mem_addr   (rsp_ch.mem_addr),
      .o_mem_value  (rsp_ch.mem_value),
      .o_fault      (rsp_ch.fault)
   );
endmodule

// ===== hdl/lc4_div.sv =====
module lc4_div (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  lc4_pkg::word_type dividend,
   input  lc4_pkg::word_type divisor,
   output logic             done,
   output lc4_pkg::word_type quotient,
   output lc4_pkg::word_type remainder
);
   import lc4_pkg::*;

   logic        busy_ff;
   logic [3:0]  count_ff;
   word_type    rem_ff, quo_ff, dsr_ff;
   logic [16:0] shifted, trial;

   assign shifted = {rem_ff, quo_ff[15]};
   assign trial   = shifted - {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else if (start) begin
         busy_ff  <= 1'b1;
         count_ff <= '0;
         rem_ff   <= '0;
         quo_ff   <= dividend;
         dsr_ff   <= divisor;
      end else if (busy_ff) begin
         // restoring step, one quotient bit a cycle
         if (!trial[16]) begin
            rem_ff <= trial[15:0];
            quo_ff <= {quo_ff[14:0], 1'b1};
         end else begin
            rem_ff <= shifted[15:0];
            quo_ff <= {quo_ff[14:0], 1'b0};
         end
         count_ff <= count_ff + 4'd1;
         if (count_ff == 4'd15) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign done      = !busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule

// ===== hdl/lc4_ctrl.sv =====
module lc4_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  lc4_pkg::dp_status_type st,
   output lc4_pkg::ctrl_cmd_type  cmd
);
   import lc4_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_FETCH, S_DECODE, S_EXEC, S_DIV, S_FINISH
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd             = '0;
      cmd.capture     = (state_ff == S_IDLE) && req_valid;
      cmd.mem_rd_pc   = (state_ff == S_FETCH);
      cmd.latch_insn  = (state_ff == S_DECODE);
      cmd.div_start   = (state_ff == S_EXEC) && !st.fault && st.is_div;
      cmd.mem_rd_addr = (state_ff == S_EXEC) && !st.fault && st.is_ldr;
      cmd.finish      = (state_ff == S_FINISH) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= (!st.req_cmd || st.halted) ? S_FINISH : S_FETCH;
               end
            end
            S_FETCH:  state_ff <= S_DECODE;
            S_DECODE: state_ff <= S_EXEC;
            S_EXEC: begin
               state_ff <= (!st.fault && st.is_div) ? S_DIV : S_FINISH;
            end
            S_DIV: begin
               if (st.div_done) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ===== hdl/lc4_dpath.sv =====
module lc4_dpath (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_cmd,
   input  lc4_pkg::word_type     in_load_addr,
   input  lc4_pkg::word_type     in_load_data,
   input  logic                  csr_we,
   input  lc4_pkg::word_type     csr_wdata,
   input  lc4_pkg::ctrl_cmd_type cmd,
   output lc4_pkg::dp_status_type st,
   output lc4_pkg::word_type     o_exec_pc,
   output lc4_pkg::word_type     o_insn_word,
   output logic                  o_reg_we,
   output logic [2:0]            o_reg_num,
   output lc4_pkg::word_type     o_reg_value,
   output logic                  o_nzp_we,
   output logic [2:0]            o_nzp,
   output logic                  o_mem_we,
   output lc4_pkg::word_type     o_mem_addr,
   output lc4_pkg::word_type     o_mem_value,
   output logic                  o_fault
);
   import lc4_pkg::*;

   word_type   rf_ff [8];
   word_type   pc_ff, insn_ff, mem_rd_ff;
   logic       priv_ff, halted_ff, cmd_ff;
   logic [2:0] nzp_ff;
   word_type   laddr_ff, ldata_ff;
   word_type   mem [0:65535];

   word_type   out_pc_ff, out_insn_ff, out_rval_ff, out_maddr_ff, out_mval_ff;
   logic       out_rwe_ff, out_nwe_ff, out_mwe_ff, out_fault_ff;
   logic [2:0] out_rnum_ff, out_nzp_ff;

   logic [3:0] op;
   logic [2:0] d, s, t;
   word_type   a, b, rd, sx5, sx6, sx7, sx9, sx11, dmem_addr, jsr_tgt, next, r, mval;
   logic       wreg, wnzp, store, load, fault, is_div;
   logic [2:0] wnum, nz;
   logic       div_done;
   word_type   div_q, div_r;
   logic       mem_we;
   word_type   mem_waddr, mem_wdata;

   function automatic logic [2:0] flags_of(word_type v);
      if (v == '0) return NZP_Z;
      return v[15] ? NZP_N : NZP_P;
   endfunction

   function automatic logic [2:0] flags_cmp(logic lt, logic eq);
      if (eq) return NZP_Z;
      return lt ? NZP_N : NZP_P;
   endfunction

   assign op   = insn_ff[15:12];
   assign d    = insn_ff[11:9];
   assign s    = insn_ff[8:6];
   assign t    = insn_ff[2:0];
   assign a    = rf_ff[s];
   assign b    = rf_ff[t];
   assign rd   = rf_ff[d];
   assign sx5  = {{11{insn_ff[4]}}, insn_ff[4:0]};
   assign sx6  = {{10{insn_ff[5]}}, insn_ff[5:0]};
   assign sx7  = {{9{insn_ff[6]}}, insn_ff[6:0]};
   assign sx9  = {{7{insn_ff[8]}}, insn_ff[8:0]};
   assign sx11 = {{5{insn_ff[10]}}, insn_ff[10:0]};
   assign dmem_addr = a + sx6;
   assign jsr_tgt   = insn_ff[11] ? {pc_ff[15], insn_ff[10:0], 4'b0000} : a;
   assign is_div = ((op == OP_ARITH) && (insn_ff[5:3] == ALU_DIV))
                || ((op == OP_SHIFT) && (insn_ff[5:4] == SH_MOD));

   always_comb begin
      next  = pc_ff + 16'd1;
      r     = '0;
      mval  = '0;
      wreg  = 1'b0;
      wnzp  = 1'b0;
      store = 1'b0;
      load  = 1'b0;
      wnum  = d;
      nz    = '0;
      fault = !priv_ff && (pc_ff >= USER_CODE_END);
      unique case (op)
         OP_BR: begin
            if ((insn_ff[11:9] & nzp_ff) != 3'd0) next = pc_ff + 16'd1 + sx9;
         end
         OP_ARITH: begin
            wreg = 1'b1;
            case (insn_ff[5:3])
               ALU_ADD: r = a + b;
               ALU_MUL: r = a * b;
               ALU_SUB: r = a - b;
               ALU_DIV: r = (b == '0) ? '0 : div_q;
               default: r = a + sx5;
            endcase
         end
         OP_CMP: begin
            wnzp = 1'b1;
            case (insn_ff[8:7])
               CMP_S:   nz = flags_cmp($signed(rd) < $signed(b), rd == b);
               CMP_U:   nz = flags_cmp(rd < b, rd == b);
               CMP_SI:  nz = flags_cmp($signed(rd) < $signed(sx7), rd == sx7);
               default: nz = flags_cmp(rd < {9'd0, insn_ff[6:0]},
                                       rd == {9'd0, insn_ff[6:0]});
            endcase
         end
         OP_JSR: begin
            if (!priv_ff && (jsr_tgt >= OS_BASE)) fault = 1'b1;
            wreg = 1'b1;
            wnum = 3'd7;
            next = jsr_tgt;
            r    = pc_ff + 16'd1;
         end
         OP_LOGIC: begin
            wreg = 1'b1;
            case (insn_ff[5:3])
               LOG_AND: r = a & b;
               LOG_NOT: r = ~a;
               LOG_OR:  r = a | b;
               LOG_XOR: r = a ^ b;
               default: r = a & sx5;
            endcase
         end
         OP_LDR: begin
            if (!priv_ff && ((dmem_addr < USER_CODE_END) || (dmem_addr >= OS_BASE)))
               fault = 1'b1;
            r    = mem_rd_ff;
            mval = mem_rd_ff;
            load = 1'b1;
            wreg = 1'b1;
         end
         OP_STR: begin
            if (!priv_ff && ((dmem_addr < USER_CODE_END) || (dmem_addr >= OS_BASE)))
               fault = 1'b1;
            mval  = rd;
            store = 1'b1;
         end
         OP_RTI:   next = rf_ff[7];
         OP_CONST: begin
            wreg = 1'b1;
            r    = sx9;
         end
         OP_SHIFT: begin
            wreg = 1'b1;
            case (insn_ff[5:4])
               SH_SLL:  r = a << insn_ff[3:0];
               SH_SRA:  r = word_type'($signed(a) >>> insn_ff[3:0]);
               SH_SRL:  r = a >> insn_ff[3:0];
               default: r = (b == '0) ? '0 : div_r;
            endcase
         end
         OP_JMP: next = insn_ff[11] ? (pc_ff + 16'd1 + sx11) : a;
         OP_HICON: begin
            wreg = 1'b1;
            r    = {insn_ff[7:0], rd[7:0]};
         end
         OP_TRAP: begin
            wreg = 1'b1;
            wnum = 3'd7;
            r    = pc_ff + 16'd1;
            next = {OS_BASE[15:8], insn_ff[7:0]};
         end
         default: fault = 1'b1;
      endcase
      if (wreg) begin
         nz   = flags_of(r);
         wnzp = 1'b1;
      end
   end

   lc4_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (a),
      .divisor   (b),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   assign st.req_cmd  = in_cmd;
   assign st.halted   = halted_ff;
   assign st.fault    = fault;
   assign st.is_div   = is_div;
   assign st.is_ldr   = (op == OP_LDR);
   assign st.div_done = div_done;

   // single memory port: one write, one registered read
   assign mem_we    = cmd.finish && (!cmd_ff || (!halted_ff && !fault && store));
   assign mem_waddr = cmd_ff ? dmem_addr : laddr_ff;
   assign mem_wdata = cmd_ff ? mval : ldata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (cmd.mem_rd_pc) mem_rd_ff <= mem[pc_ff];
      else if (cmd.mem_rd_addr) mem_rd_ff <= mem[dmem_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff   <= in_cmd;
         laddr_ff <= in_load_addr;
         ldata_ff <= in_load_data;
      end
      if (cmd.latch_insn) insn_ff <= mem_rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) rf_ff[i] <= '0;
         pc_ff     <= RESET_PC;
         priv_ff   <= 1'b1;
         nzp_ff    <= NZP_Z;
         halted_ff <= 1'b0;
      end else if (csr_we) begin
         pc_ff <= csr_wdata;
      end else if (cmd.finish && cmd_ff && !halted_ff) begin
         if (fault) begin
            pc_ff     <= FAULT_PC;
            halted_ff <= 1'b1;
         end else begin
            pc_ff <= next;
            if (wreg) rf_ff[wnum] <= r;
            if (wnzp) nzp_ff <= nz;
            if (op == OP_RTI) priv_ff <= 1'b0;
            if (op == OP_TRAP) priv_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         out_pc_ff    <= '0;
         out_insn_ff  <= '0;
         out_rwe_ff   <= 1'b0;
         out_rnum_ff  <= '0;
         out_rval_ff  <= '0;
         out_nwe_ff   <= 1'b0;
         out_nzp_ff   <= '0;
         out_mwe_ff   <= 1'b0;
         out_maddr_ff <= '0;
         out_mval_ff  <= '0;
         out_fault_ff <= 1'b0;
         if (cmd_ff && halted_ff) begin
            out_pc_ff    <= pc_ff;
            out_fault_ff <= 1'b1;
         end else if (cmd_ff) begin
            out_pc_ff   <= pc_ff;
            out_insn_ff <= insn_ff;
            if (fault) begin
               out_fault_ff <= 1'b1;
            end else begin
               out_rwe_ff  <= wreg;
               out_rnum_ff <= wreg ? wnum : 3'd0;
               out_rval_ff <= wreg ? r : '0;
               out_nwe_ff  <= wnzp;
               out_nzp_ff  <= nz;
               out_mwe_ff  <= store;
               if (load || store) begin
                  out_maddr_ff <= dmem_addr;
                  out_mval_ff  <= mval;
               end
            end
         end
      end
   end

   assign o_exec_pc   = out_pc_ff;
   assign o_insn_word = out_insn_ff;
   assign o_reg_we    = out_rwe_ff;
   assign o_reg_num   = out_rnum_ff;
   assign o_reg_value = out_rval_ff;
   assign o_nzp_we    = out_nwe_ff;
   assign o_nzp       = out_nzp_ff;
   assign o_mem_we    = out_mwe_ff;
   assign o_mem_addr  = out_maddr_ff;
   assign o_mem_value = out_mval_ff;
   assign o_fault     = out_fault_ff;
endmodule

// ===== hdl/lc4_checker.sv =====
module lc4_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        reg_we,
   input logic [2:0]  reg_num,
   input logic [15:0] reg_value,
   input logic        nzp_we,
   input logic        mem_we,
   input logic        fault
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("trace dropped");
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("trace after reset");
   a_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && fault |-> !reg_we && !nzp_we && !mem_we)
      else $error("fault with side effects");
   a_noreg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !reg_we |-> reg_num == 3'd0 && reg_value == 16'd0)
      else $error("stale register fields");
   a_store: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && mem_we |-> !reg_we && !nzp_we)
      else $error("store wrote a register");
endmodule

bind sixteen_bit_instruction_executor lc4_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .reg_we    (rsp_ch.reg_we),
   .reg_num   (rsp_ch.reg_num),
   .reg_value (rsp_ch.reg_value),
   .nzp_we    (rsp_ch.nzp_we),
   .mem_we    (rsp_ch.mem_we),
   .fault     (rsp_ch.fault)
);
